// ----- rtl/zrs_pkg.sv -----
package zrs_pkg;

  // Operation codes carried on the op input.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Status of the search engine as seen by the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } search_status_t;

endpackage

// ----- rtl/zrs_ram.sv -----
module zrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/zrs_search.sv -----
module zrs_search import zrs_pkg::*; #(
  parameter int MAX_RANKS = 1024,
  parameter int FRACTION_BITS = 32,
  localparam int RANK_W = $clog2(MAX_RANKS + 1),
  localparam int CW = RANK_W + 1,
  localparam int AW = $clog2(MAX_RANKS)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [FRACTION_BITS-1:0] z_in,
  input  logic [RANK_W-1:0]        count,
  input  logic [FRACTION_BITS-1:0] rd_hi,
  input  logic [FRACTION_BITS-1:0] rd_lo,
  output logic [AW-1:0]            addr_hi,
  output logic [AW-1:0]            addr_lo,
  output search_status_t           status,
  output logic [RANK_W-1:0]        rank
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_t;

  localparam logic [RANK_W-1:0] ONE = RANK_W'(1);
  localparam logic [RANK_W-1:0] TWO = RANK_W'(2);
  localparam logic [RANK_W-1:0] MAX_N = RANK_W'(MAX_RANKS);

  state_t                   state, state_next;
  logic [RANK_W-1:0]        lo, lo_next;
  logic [RANK_W-1:0]        hi, hi_next;
  logic [RANK_W-1:0]        mid, mid_next;
  logic [RANK_W-1:0]        rank_next;
  logic                     done, done_next;
  logic [FRACTION_BITS-1:0] z;
  logic [RANK_W-1:0]        count_sat;
  logic [CW-1:0]            sum_start, sum_ge, sum_lt;
  logic                     hit_ge, hit_lt;

  assign count_sat = (count > MAX_N) ? MAX_N : count;

  // Candidate midpoints for both outcomes are formed beside the compare.
  assign sum_start = CW'(1) + {1'b0, count_sat};
  assign sum_ge    = {1'b0, lo} + {1'b0, mid} - CW'(1);
  assign sum_lt    = {1'b0, mid} + {1'b0, hi} + CW'(1);

  // The entry below rank one, cdf[0], is a fixed zero, below any nonzero z.
  assign hit_ge = (rd_hi >= z);
  assign hit_lt = (mid == ONE) ? (z != '0) : (rd_lo < z);

  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    rank_next  = rank;
    done_next  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (count_sat == '0) begin
            done_next = 1'b1;
            rank_next = '0;
          end else begin
            lo_next    = ONE;
            hi_next    = count_sat;
            mid_next   = RANK_W'(sum_start >> 1);
            state_next = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (hit_ge && hit_lt) begin
          done_next  = 1'b1;
          rank_next  = mid;
          state_next = ST_IDLE;
        end else if (hit_ge) begin
          if (lo < mid) begin
            hi_next  = mid - ONE;
            mid_next = RANK_W'(sum_ge >> 1);
          end else begin
            done_next  = 1'b1;
            rank_next  = '0;
            state_next = ST_IDLE;
          end
        end else begin
          if (mid < hi) begin
            lo_next  = mid + ONE;
            mid_next = RANK_W'(sum_lt >> 1);
          end else begin
            done_next  = 1'b1;
            rank_next  = '0;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Rank r lives at address r-1; the lower neighbor of rank one is unused.
  assign addr_hi = AW'(mid_next - ONE);
  assign addr_lo = (mid_next == ONE) ? '0 : AW'(mid_next - TWO);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    lo   <= lo_next;
    hi   <= hi_next;
    mid  <= mid_next;
    rank <= rank_next;
    if (state == ST_IDLE && start) begin
      z <= z_in;
    end
  end

  assign status.busy = (state == ST_SEARCH);
  assign status.done = done;

  a_window: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEARCH |-> (lo <= mid) && (mid <= hi) && (lo != '0))
    else $error("search window is inconsistent");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_SEARCH) || $past(start && count_sat == '0))
    else $error("result strobe without a finished search");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_IDLE)
    else $error("result strobe while still searching");

  a_hit_checked: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH && hit_ge && hit_lt) |=> done && rank == $past(mid))
    else $error("matched rank not delivered");

endmodule

// ----- rtl/zipf_rank_sampler_unit.sv -----
// Inverse-CDF rank sampler for a Zipf or any other discrete distribution.
// Software loads cumulative probabilities cdf[1..N] as unsigned fractions,
// one entry per transfer with op = load; cdf[0] is taken as zero. A sample
// transfer (op = sample) carries a uniform fraction z, and the block returns
// the rank k with cdf[k] >= z and cdf[k-1] < z, or rank 0 if none matches.
// An input transfer happens at a clock edge where start is high and busy low.
// A load is written to the table in that edge and causes no result; busy
// stays low, so the next transfer may follow in the next cycle.
// A sample raises busy for the binary search: one probe per cycle, both
// neighbors read together from a dual-read-port table memory.
// With rank_count at zero no search runs, busy stays low and rank 0 is
// registered as the result straight from the transfer.
// The result is on rank for one cycle with done high; the receiver cannot
// stall it, and a new transfer can be made in that same cycle.
// The user must write rank_count through cfg_we / cfg_wdata only while
// the block is idle; the block itself does not enforce it.
// Synchronous reset clears the sequencer and sets rank_count to the smaller
// of MAX_RANKS and 1024; the table is not cleared, so every entry a search
// touches must be loaded first.
module zipf_rank_sampler_unit import zrs_pkg::*; #(
  parameter int MAX_RANKS = 1024,
  parameter int FRACTION_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              op,
  input  logic [$clog2(MAX_RANKS + 1)-1:0]  load_rank,
  input  logic [FRACTION_BITS-1:0]          cdf_value,
  input  logic [FRACTION_BITS-1:0]          uniform_value,
  output logic                              done,
  output logic [$clog2(MAX_RANKS + 1)-1:0]  rank,
  input  logic                              cfg_we,
  input  logic [$clog2(MAX_RANKS + 1)-1:0]  cfg_wdata
);

  localparam int RANK_W = $clog2(MAX_RANKS + 1);
  localparam int AW = $clog2(MAX_RANKS);
  localparam logic [RANK_W-1:0] MAX_N = RANK_W'(MAX_RANKS);
  localparam logic [RANK_W-1:0] RESET_COUNT =
    RANK_W'((MAX_RANKS < 1024) ? MAX_RANKS : 1024);

  logic                     accept;
  logic                     load_we;
  logic [AW-1:0]            load_addr;
  logic [RANK_W-1:0]        rank_count;
  logic [AW-1:0]            addr_hi, addr_lo;
  logic [FRACTION_BITS-1:0] rd_hi, rd_lo;
  search_status_t           status;

  assign accept = start && !busy;

  // Loads outside ranks 1..MAX_RANKS are dropped.
  assign load_we   = accept && (op == OP_LOAD) && (load_rank != '0) && (load_rank <= MAX_N);
  assign load_addr = AW'(load_rank - RANK_W'(1));

  // A rank_count above the table size is saturated inside the search engine.
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_count <= RESET_COUNT;
    end else if (cfg_we) begin
      rank_count <= cfg_wdata;
    end
  end

  // Table memory: rank r at address r-1, read at the probe and its neighbor.
  zrs_ram #(
    .WIDTH (FRACTION_BITS),
    .DEPTH (MAX_RANKS)
  ) u_table (
    .clk     (clk),
    .we      (load_we),
    .waddr   (load_addr),
    .wdata   (cdf_value),
    .raddr_a (addr_hi),
    .rdata_a (rd_hi),
    .raddr_b (addr_lo),
    .rdata_b (rd_lo)
  );

  zrs_search #(
    .MAX_RANKS     (MAX_RANKS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_search (
    .clk     (clk),
    .rst     (rst),
    .start   (accept && (op == OP_SAMPLE)),
    .z_in    (uniform_value),
    .count   (rank_count),
    .rd_hi   (rd_hi),
    .rd_lo   (rd_lo),
    .addr_hi (addr_hi),
    .addr_lo (addr_lo),
    .status  (status),
    .rank    (rank)
  );

  assign busy = status.busy;
  assign done = status.done;

endmodule
